// ===== sv/i2c_master_byte_engine_assert.svh =====
// Assertion macros for the checker file of the I2C master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Concurrent assertion on clk, off while rst_n is low.
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/i2cm_pkg.sv =====
// Shared types and constants of the I2C master byte engine
package i2cm_pkg;

  localparam int unsigned TickW = 8;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_SETUP = 2'd0,
    REG_HIGH  = 2'd1,
    REG_FREE  = 2'd2,
    REG_HOLD  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TickW-1:0] setup_ticks;
    logic [TickW-1:0] high_ticks;
    logic [TickW-1:0] free_ticks;
    logic [TickW-1:0] hold_ticks;
  } timing_t;

  typedef struct packed {
    logic       rejected;
    logic       ack_bit;
    logic [7:0] read_value;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

// ===== sv/i2cm_core.sv =====
// Bus sequencer: holds engine state and computes one result per accepted tick
module i2cm_core import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick_en,
  input  logic [2:0] kind,
  input  logic [7:0] data,
  input  logic       send_nack,
  input  logic       sda_level,
  input  timing_t    timing,
  output result_t    result
);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_STOP_LOW    = 3'd1,
    PH_STOP_HIGH   = 3'd2,
    PH_STOP_FREE   = 3'd3,
    PH_START_HOLD  = 3'd4,
    PH_START_SETUP = 3'd5,
    PH_BIT_LOW     = 3'd6,
    PH_BIT_HIGH    = 3'd7
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [TickW-1:0] wait_r, wait_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             ack_r, ack_nxt;
  logic             nack_r, nack_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [7:0]       rx_r, rx_nxt;
  logic             done_c, rej_c;

  always_comb begin
    logic       fin;
    logic [3:0] bit_inc;
    fin       = 1'b0;
    bit_inc   = bit_r + 4'd1;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    wait_nxt  = wait_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    nack_nxt  = nack_r;
    op_nxt    = op_r;
    rx_nxt    = rx_r;
    done_c    = 1'b0;
    rej_c     = 1'b0;
    if (phase_r == PH_IDLE) begin
      case (kind)
        KIND_START, KIND_STOP: begin
          op_nxt    = kind;
          phase_nxt = PH_STOP_LOW;
          wait_nxt  = timing.setup_ticks;
        end
        KIND_WRITE: begin
          op_nxt    = kind;
          bit_nxt   = 4'd0;
          sda_nxt   = data[7];
          shift_nxt = {data[6:0], 1'b0};
          phase_nxt = PH_BIT_LOW;
          wait_nxt  = timing.setup_ticks;
        end
        KIND_READ: begin
          op_nxt    = kind;
          nack_nxt  = send_nack;
          shift_nxt = 8'd0;
          bit_nxt   = 4'd0;
          sda_nxt   = 1'b1;
          phase_nxt = PH_BIT_LOW;
          wait_nxt  = timing.setup_ticks;
        end
        default: begin
        end
      endcase
    end else begin
      rej_c = (kind inside {KIND_START, KIND_STOP, KIND_WRITE, KIND_READ});
      if (wait_r > TickW'(1)) begin
        wait_nxt = wait_r - TickW'(1);
      end else begin
        case (phase_r)
          PH_STOP_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_STOP_HIGH;
            wait_nxt  = timing.high_ticks;
          end
          PH_STOP_HIGH: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_STOP_FREE;
            wait_nxt  = timing.free_ticks;
          end
          PH_STOP_FREE: begin
            if (op_r == KIND_START) begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_START_HOLD;
              wait_nxt  = timing.hold_ticks;
            end else begin
              fin = 1'b1;
            end
          end
          PH_START_HOLD: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_START_SETUP;
            wait_nxt  = timing.setup_ticks;
          end
          PH_BIT_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_BIT_HIGH;
            wait_nxt  = timing.high_ticks;
          end
          PH_BIT_HIGH: begin
            scl_nxt = 1'b0;
            if (bit_r < 4'd8) begin
              if (op_r == KIND_READ) shift_nxt = {shift_r[6:0], sda_level};
              bit_nxt = bit_inc;
              if (bit_inc < 4'd8) begin
                if (op_r == KIND_WRITE) begin
                  sda_nxt   = shift_r[7];
                  shift_nxt = {shift_r[6:0], 1'b0};
                end
              end else if (op_r == KIND_WRITE) begin
                sda_nxt = 1'b1;
              end else begin
                sda_nxt = nack_r;
              end
              phase_nxt = PH_BIT_LOW;
              wait_nxt  = timing.setup_ticks;
            end else begin
              if (op_r == KIND_WRITE) ack_nxt = sda_level;
              else                    rx_nxt  = shift_r;
              sda_nxt = 1'b0;
              fin     = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          phase_nxt = PH_IDLE;
          wait_nxt  = '0;
          done_c    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= 4'd0;
      wait_r  <= '0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      nack_r  <= 1'b0;
      op_r    <= 3'd0;
      rx_r    <= 8'd0;
    end else if (tick_en) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      wait_r  <= wait_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      nack_r  <= nack_nxt;
      op_r    <= op_nxt;
      rx_r    <= rx_nxt;
    end
  end

  always_comb begin
    result.scl_release = scl_nxt;
    result.sda_release = sda_nxt;
    result.busy_res    = (phase_nxt != PH_IDLE);
    result.done_res    = done_c;
    result.read_value  = rx_nxt;
    result.ack_bit     = ack_nxt;
    result.rejected    = rej_c;
  end

endmodule

// ===== sv/i2c_master_byte_engine.sv =====
// Top level of the tick-driven I2C master byte engine
// Usage:
//   in_*  : one transaction per timing tick. tuser carries the command kind
//           (tick only, start, stop, write byte, read byte); tdata carries
//           the write byte, the NACK choice for reads and the sampled SDA.
//   out_* : one result transaction per tick: SCL/SDA release levels after
//           the tick, busy, done, last read byte, last write ACK, rejected.
//   cfg_* : write one of four tick-count registers (setup, high, free, hold);
//           write only while the engine is idle. Always ready.
// A tick's result lands in the output register, or in the skid stage on a stall.
// Throughput: one tick per cycle while the receiver keeps up; the sequencer
//   state advances in the cycle of acceptance and the output register plus a
//   one-entry skid stage part the two sides.
// Reset (rst_n low, synchronous): idle, both lines released, registers back
//   to setup 2, high 4, free 3, hold 4, no result pending.
// Stall: when out_tready is low the result waits in the output register,
//   one more tick is taken into the skid stage, then in_tready drops until
//   the receiver drains it. Line state only moves on accepted ticks.
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // kind
  input  logic [15:0] in_tdata,   // data[7:0], send_nack[8], sda_level[9], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_release[0], sda_release[1], busy_res[2],
                                  // done_res[3], read_value[11:4], ack_bit[12],
                                  // rejected[13], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  timing_t timing_r;
  result_t result_c;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    in_fire, out_fire;

  assign in_tready = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // Tick-count registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.setup_ticks <= TickW'(2);
      timing_r.high_ticks  <= TickW'(4);
      timing_r.free_ticks  <= TickW'(3);
      timing_r.hold_ticks  <= TickW'(4);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETUP: timing_r.setup_ticks <= cfg_data;
        REG_HIGH:  timing_r.high_ticks  <= cfg_data;
        REG_FREE:  timing_r.free_ticks  <= cfg_data;
        REG_HOLD:  timing_r.hold_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  i2cm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_en   (in_fire),
    .kind      (in_tuser),
    .data      (in_tdata[7:0]),
    .send_nack (in_tdata[8]),
    .sda_level (in_tdata[9]),
    .timing    (timing_r),
    .result    (result_c)
  );

  // Output register with one skid entry: drain the skid first, otherwise
  // land a new result in the output register or park it in the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) out_r  <= result_c;
      else                          skid_r <= result_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(16 - ResultW)'(0), out_r};

endmodule

// ===== sv/i2cm_checker.sv =====
// Port-level checker for the I2C master byte engine, bound to the top level
`include "i2c_master_byte_engine_assert.svh"

module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A completing tick always leaves the engine idle.
  `I2CM_ASSERT(a_done_idle, out_tvalid && out_tdata[3] |-> !out_tdata[2], "done while busy")
  // Input stalls only while a result waits to be taken.
  `I2CM_ASSERT(a_stall_cause, !in_tready |-> out_tvalid, "input stalled with no result pending")
  // A stalled result stays offered.
  `I2CM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result withdrawn")
  // A stalled result keeps its payload.
  `I2CM_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
